FILE: rtl/alu8f_pkg.sv
// ----------------------------------------------------------------------------
// alu8f_pkg
// Operation codes and flag layout shared by the 8-bit ALU and its top level.
// ----------------------------------------------------------------------------
package alu8f_pkg;

  localparam int unsigned DataW = 8;
  localparam int unsigned WideW = 16;
  localparam int unsigned CmdW  = 4;
  localparam int unsigned FlagW = 4;

  localparam logic [WideW-1:0] HighMask = 16'hff00;
  localparam logic [DataW-1:0] SignBit  = 8'h80;

  typedef enum logic [CmdW-1:0] {
    CMD_ADD  = 4'd0,
    CMD_SUB  = 4'd1,
    CMD_NEG  = 4'd2,
    CMD_SHL  = 4'd3,
    CMD_SHLC = 4'd4,
    CMD_INC  = 4'd5,
    CMD_ADC  = 4'd6,
    CMD_SBC  = 4'd7,
    CMD_NOT  = 4'd8,
    CMD_AND  = 4'd9,
    CMD_OR   = 4'd10,
    CMD_XOR  = 4'd11,
    CMD_ZERO = 4'd12,
    CMD_NOP  = 4'd13,
    CMD_SHR  = 4'd14,
    CMD_SHRC = 4'd15
  } cmd_t;

  typedef struct packed {
    logic overflow;
    logic sign;
    logic zero;
    logic carry;
  } flags_t;

endpackage

FILE: rtl/alu_8bit_with_flags.sv
// ----------------------------------------------------------------------------
// alu_8bit_with_flags
// Two-stage valid/ready wrapper around an 8-bit ALU with four flags.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_ready carry one beat of cmd, operand_a,
// operand_b and carry_in. Output channel: out_valid/out_ready carry one
// beat of result and flags (bit3 overflow, bit2 sign, bit1 zero, bit0 carry).
// Each input beat gives exactly one output beat, in order.
// A beat accepted into the input register passes through the ALU logic into
// the result register, which holds its answer until the receiver takes it.
// Throughput: one beat per cycle while the receiver keeps taking result
// beats, set by the single ALU pass.
// Reset (rst, synchronous, active high) empties both stages; out_valid and
// in_ready follow from there. When the receiver stalls, the result register
// holds its beat, the input register fills, and in_ready drops only once
// both stages are full.
// ----------------------------------------------------------------------------
module alu_8bit_with_flags (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [alu8f_pkg::CmdW-1:0]    cmd,
  input  logic [alu8f_pkg::DataW-1:0]   operand_a,
  input  logic [alu8f_pkg::DataW-1:0]   operand_b,
  input  logic                          carry_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [alu8f_pkg::DataW-1:0]   result,
  output logic [alu8f_pkg::FlagW-1:0]   flags
);

  logic                        s1_valid;
  logic                        s1_ready;
  alu8f_pkg::cmd_t             s1_cmd;
  logic [alu8f_pkg::DataW-1:0] s1_a;
  logic [alu8f_pkg::DataW-1:0] s1_b;
  logic                        s1_c;

  logic [alu8f_pkg::DataW-1:0] alu_result;
  alu8f_pkg::flags_t           alu_flags;
  alu8f_pkg::flags_t           flags_q;

  assign s1_ready = !out_valid || out_ready;
  assign in_ready = !s1_valid || s1_ready;

  // advance the input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_cmd <= alu8f_pkg::cmd_t'(cmd);
      s1_a   <= operand_a;
      s1_b   <= operand_b;
      s1_c   <= carry_in;
    end
  end

  alu8f_core u_core (
    .cmd       (s1_cmd),
    .operand_a (s1_a),
    .operand_b (s1_b),
    .carry_in  (s1_c),
    .result    (alu_result),
    .flags     (alu_flags)
  );

  // hold the result beat until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_ready) begin
      result  <= alu_result;
      flags_q <= alu_flags;
    end
  end

  assign flags = flags_q;

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && !out_ready) |-> !in_ready)
    else $error("input accepted while both stages are full and stalled");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_ready) |=> out_valid)
    else $error("input stage beat lost on its way to the result register");

  a_zero_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (flags[1] == (result == 8'h00)))
    else $error("zero flag disagrees with result");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!out_valid && !s1_valid))
    else $error("pipeline not empty after reset");

endmodule

FILE: rtl/alu8f_core.sv
// ----------------------------------------------------------------------------
// alu8f_core
// Single-pass 8-bit operation with a 16-bit intermediate and four flags.
// ----------------------------------------------------------------------------
module alu8f_core (
  input  alu8f_pkg::cmd_t                  cmd,
  input  logic [alu8f_pkg::DataW-1:0]      operand_a,
  input  logic [alu8f_pkg::DataW-1:0]      operand_b,
  input  logic                             carry_in,
  output logic [alu8f_pkg::DataW-1:0]      result,
  output alu8f_pkg::flags_t                flags
);

  logic [alu8f_pkg::WideW-1:0] a_w;
  logic [alu8f_pkg::WideW-1:0] b_w;
  logic [alu8f_pkg::WideW-1:0] c_w;
  logic [alu8f_pkg::WideW-1:0] t;
  logic                        ovf;

  assign a_w = {8'h00, operand_a};
  assign b_w = {8'h00, operand_b};
  assign c_w = {15'h0000, carry_in};

  always_comb begin
    t   = '0;
    ovf = 1'b0;
    case (cmd)
      alu8f_pkg::CMD_ADD: begin
        t   = a_w + b_w;
        ovf = |((operand_a ^ t[7:0]) & (operand_b ^ t[7:0]) & alu8f_pkg::SignBit);
      end
      alu8f_pkg::CMD_SUB: begin
        t   = a_w - b_w;
        ovf = |((operand_a ^ operand_b) & (operand_a ^ t[7:0]) & alu8f_pkg::SignBit);
      end
      alu8f_pkg::CMD_NEG:  t = 16'h0000 - a_w;
      alu8f_pkg::CMD_SHL:  t = {a_w[14:0], 1'b0};
      alu8f_pkg::CMD_SHLC: t = {a_w[14:0], 1'b0} + c_w;
      alu8f_pkg::CMD_INC:  t = a_w + 16'h0001;
      alu8f_pkg::CMD_ADC: begin
        t   = a_w + b_w + c_w;
        ovf = |((operand_a ^ t[7:0]) & (operand_b ^ t[7:0]) & alu8f_pkg::SignBit);
      end
      alu8f_pkg::CMD_SBC: begin
        t   = a_w - b_w - c_w;
        ovf = |((operand_a ^ operand_b) & (operand_a ^ t[7:0]) & alu8f_pkg::SignBit);
      end
      alu8f_pkg::CMD_NOT:  t = alu8f_pkg::HighMask | {8'h00, ~operand_a};
      alu8f_pkg::CMD_AND:  t = a_w & b_w;
      alu8f_pkg::CMD_OR:   t = a_w | b_w;
      alu8f_pkg::CMD_XOR:  t = a_w ^ b_w;
      alu8f_pkg::CMD_ZERO: t = '0;
      alu8f_pkg::CMD_NOP:  t = a_w;
      alu8f_pkg::CMD_SHR:  t = {7'h00, operand_a[0], 1'b0, operand_a[7:1]};
      alu8f_pkg::CMD_SHRC: t = {7'h00, operand_a[0], carry_in, operand_a[7:1]};
      default: begin
        t   = '0;
        ovf = 1'b0;
      end
    endcase
  end

  assign result         = t[7:0];
  assign flags.overflow = ovf;
  assign flags.sign     = t[7];
  assign flags.zero     = (t[7:0] == 8'h00);
  assign flags.carry    = |(t & alu8f_pkg::HighMask);

endmodule
